// ----- hdl/lfs_pkg.sv -----
// Shared types, codes and constants for the link failover selector.
package lfs_pkg;

   localparam int LINK_COUNT = 3;

   typedef logic [1:0] link_type;

   localparam link_type LINK_NONE     = 2'd0;
   localparam link_type LINK_CELL     = 2'd1;
   localparam link_type LINK_WIRED    = 2'd2;
   localparam link_type LINK_WIRELESS = 2'd3;

   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_FAIL = 2'd1;
   localparam logic [1:0] REQ_OK   = 2'd2;

   localparam logic [1:0] CSR_MODE           = 2'd0;
   localparam logic [1:0] CSR_CHECK_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_AVOID_TIME     = 2'd2;

   localparam int CSR_DATA_WIDTH = 24;

   localparam logic [1:0]  MODE_RESET           = 2'd0;
   localparam logic [15:0] CHECK_INTERVAL_RESET = 16'd1000;
   localparam logic [23:0] AVOID_TIME_RESET     = 24'd60000;

   typedef link_type order_type [LINK_COUNT];

   // Priority order per mode, highest first.
   localparam order_type PRIO_TABLE [4] = '{
      '{LINK_CELL,     LINK_WIRELESS, LINK_WIRED},
      '{LINK_WIRELESS, LINK_WIRED,    LINK_CELL},
      '{LINK_CELL,     LINK_NONE,     LINK_NONE},
      '{LINK_WIRELESS, LINK_NONE,     LINK_NONE}
   };

   typedef struct packed {
      logic [1:0] req_type;
      logic       up_cell;
      logic       up_wired;
      logic       up_wireless;
   } item_type;

   typedef struct packed {
      link_type    active_link;
      logic        switched;
      logic        link_usable;
      logic [31:0] switch_count;
   } result_type;

   // Map a link code (not none) to its slot in per-link state.
   function automatic logic [1:0] link_index(link_type code);
      return code - 2'd1;
   endfunction

endpackage

// ----- hdl/lfs_req_if.sv -----
// Request and response channel interfaces.
interface lfs_req_if;
   import lfs_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic       up_cell;
   logic       up_wired;
   logic       up_wireless;

   modport source (output valid, req_type, up_cell, up_wired, up_wireless, input ready);
   modport sink   (input valid, req_type, up_cell, up_wired, up_wireless, output ready);
endinterface

interface lfs_rsp_if;
   import lfs_pkg::*;
   logic        valid;
   logic        ready;
   link_type    active_link;
   logic        switched;
   logic        link_usable;
   logic [31:0] switch_count;

   modport source  (output valid, active_link, switched, link_usable, switch_count,
                    input ready);
   modport sink    (input valid, active_link, switched, link_usable, switch_count,
                    output ready);
   modport monitor (input valid, ready, active_link, switched, link_usable, switch_count);
endinterface

// ----- hdl/link_failover_selector_unit.sv -----
// Top level of the link failover selector: input stage, core and output stage.
//
//   channel   direction  handshake         payload
//   req_if    in         valid / ready     req_type, up_cell, up_wired, up_wireless
//   rsp_if    out        valid / ready     active_link, switched, link_usable, switch_count
//   csr_*     in         write enable      index (2 bits), data (24 bits)
//
// rsp valid rises when the result register is loaded: the req item is first held in
// the input register, then the core updates state and loads the result register.
// While rsp is not stalled a new item is accepted every cycle; the rate is one item per cycle.
// Reset is synchronous; it clears the stage valids, resets all selection state and
// restores the register defaults.
// When rsp is stalled the result register holds and the input register fills;
// req_if.ready drops only when both are occupied.
module link_failover_selector_unit
   import lfs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   lfs_req_if.sink                   req_if,
   lfs_rsp_if.source                 rsp_if,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_write_data
);

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_result_ff;
   result_type core_result;
   logic       req_fire;
   logic       advance;

   // Advance the input stage into the result register when that frees up.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;
   assign req_fire      = req_if.valid && req_if.ready;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the transfer payload; hold it until it advances.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.req_type    <= req_if.req_type;
         in_item_ff.up_cell     <= req_if.up_cell;
         in_item_ff.up_wired    <= req_if.up_wired;
         in_item_ff.up_wireless <= req_if.up_wireless;
      end
   end

   lfs_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .step             (advance),
      .item             (in_item_ff),
      .result           (core_result)
   );

   // Load the result when the item advances; hold it while stalled.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.active_link  = out_result_ff.active_link;
   assign rsp_if.switched     = out_result_ff.switched;
   assign rsp_if.link_usable  = out_result_ff.link_usable;
   assign rsp_if.switch_count = out_result_ff.switch_count;

endmodule

// ----- hdl/lfs_pick.sv -----
// Priority pick of one link from the up and avoided flags.
module lfs_pick
   import lfs_pkg::*;
(
   input  logic [1:0] mode,
   input  logic [2:0] up,
   input  logic [2:0] avoided,
   output link_type   link
);

   order_type  order;
   logic [2:0] slot_up;
   logic [2:0] slot_free;

   always_comb begin
      order = PRIO_TABLE[mode];
      for (int i = 0; i < LINK_COUNT; i++) begin
         if (order[i] == LINK_NONE) begin
            slot_up[i] = 1'b0;
         end else begin
            slot_up[i] = up[link_index(order[i])];
         end
         slot_free[i] = slot_up[i] &&
                        !(order[i] != LINK_NONE && avoided[link_index(order[i])]);
      end
   end

   // First free up link, else first up link, else none.
   always_comb begin
      priority if (slot_free[0]) begin
         link = order[0];
      end else if (slot_free[1]) begin
         link = order[1];
      end else if (slot_free[2]) begin
         link = order[2];
      end else if (slot_up[0]) begin
         link = order[0];
      end else if (slot_up[1]) begin
         link = order[1];
      end else if (slot_up[2]) begin
         link = order[2];
      end else begin
         link = LINK_NONE;
      end
   end

endmodule

// ----- hdl/lfs_core.sv -----
// Selection state, configuration registers and per-item update.
module lfs_core
   import lfs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_write_data,
   input  logic                      step,
   input  item_type                  item,
   output result_type                result
);

   logic [1:0]  mode_ff;
   logic [15:0] check_interval_ff;
   logic [23:0] avoid_time_ff;
   logic [31:0] now_ms_ff, now_ms_in;
   logic [31:0] now_inc_ff, now_inc_in;
   logic [31:0] deadline_ff [LINK_COUNT];
   logic [31:0] deadline_in [LINK_COUNT];
   link_type    current_link_ff, current_link_in;
   logic [31:0] last_check_ff, last_check_in;
   logic        forced_ff, forced_in;
   logic [31:0] switches_ff, switches_in;

   logic [2:0]  up;
   logic [2:0]  avoided;
   logic [31:0] since_dl [LINK_COUNT];
   logic [31:0] elapsed;
   logic        cur_up;
   logic        forced_now;
   logic        do_check;
   link_type    picked;
   logic        sw;
   logic [1:0]  cur_idx;

   assign up = {item.up_wireless, item.up_wired, item.up_cell};

   // Avoid test is made against the time after this tick.
   always_comb begin
      for (int i = 0; i < LINK_COUNT; i++) begin
         since_dl[i] = now_inc_ff - deadline_ff[i];
         avoided[i]  = (deadline_ff[i] != '0) && since_dl[i][31];
      end
   end

   lfs_pick u_pick (
      .mode    (mode_ff),
      .up      (up),
      .avoided (avoided),
      .link    (picked)
   );

   assign cur_idx    = link_index(current_link_ff);
   assign cur_up     = (current_link_ff != LINK_NONE) && up[cur_idx];
   assign forced_now = forced_ff || (current_link_ff != LINK_NONE && !cur_up);
   assign elapsed    = now_inc_ff - last_check_ff;
   assign do_check   = forced_now || (elapsed >= {16'd0, check_interval_ff});

   always_comb begin
      now_ms_in       = now_ms_ff;
      now_inc_in      = now_inc_ff;
      current_link_in = current_link_ff;
      last_check_in   = last_check_ff;
      forced_in       = forced_ff;
      switches_in     = switches_ff;
      sw              = 1'b0;
      for (int i = 0; i < LINK_COUNT; i++) begin
         deadline_in[i] = deadline_ff[i];
      end
      unique case (item.req_type)
         REQ_TICK: begin
            now_ms_in  = now_inc_ff;
            now_inc_in = now_inc_ff + 32'd1;
            if (do_check) begin
               last_check_in   = now_inc_ff;
               forced_in       = 1'b0;
               current_link_in = picked;
               if (picked != current_link_ff) begin
                  switches_in = switches_ff + 32'd1;
                  sw          = 1'b1;
               end
            end else begin
               forced_in = forced_now;
            end
         end
         REQ_FAIL: begin
            if (current_link_ff != LINK_NONE) begin
               deadline_in[cur_idx] = now_ms_ff + {8'd0, avoid_time_ff};
               forced_in            = 1'b1;
            end
         end
         REQ_OK: begin
            if (current_link_ff != LINK_NONE) begin
               deadline_in[cur_idx] = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.active_link  = current_link_in;
      result.switched     = sw;
      result.link_usable  = (current_link_in != LINK_NONE) &&
                            up[link_index(current_link_in)];
      result.switch_count = switches_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_RESET;
         check_interval_ff <= CHECK_INTERVAL_RESET;
         avoid_time_ff     <= AVOID_TIME_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODE:           mode_ff           <= csr_write_data[1:0];
            CSR_CHECK_INTERVAL: check_interval_ff <= csr_write_data[15:0];
            CSR_AVOID_TIME:     avoid_time_ff     <= csr_write_data[23:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ms_ff       <= '0;
         now_inc_ff      <= 32'd1;
         current_link_ff <= LINK_NONE;
         last_check_ff   <= '0;
         forced_ff       <= 1'b1;
         switches_ff     <= '0;
         for (int i = 0; i < LINK_COUNT; i++) begin
            deadline_ff[i] <= '0;
         end
      end else if (step) begin
         now_ms_ff       <= now_ms_in;
         now_inc_ff      <= now_inc_in;
         current_link_ff <= current_link_in;
         last_check_ff   <= last_check_in;
         forced_ff       <= forced_in;
         switches_ff     <= switches_in;
         for (int i = 0; i < LINK_COUNT; i++) begin
            deadline_ff[i] <= deadline_in[i];
         end
      end
   end

endmodule

// ----- hdl/lfs_checker.sv -----
// Port-level checks on the response stream of the link failover selector.
module lfs_checker
   import lfs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input link_type    rsp_active_link,
   input logic        rsp_switched,
   input logic [31:0] rsp_switch_count
);

   logic        have_last_ff;
   logic [31:0] last_count_ff;
   link_type    last_link_ff;
   logic        rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_last_ff <= 1'b0;
      end else if (rsp_fire) begin
         have_last_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         last_count_ff <= rsp_switch_count;
         last_link_ff  <= rsp_active_link;
      end
   end

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_switch_count))
      else $error("stalled response dropped or changed");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && have_last_ff |->
         (rsp_switched && rsp_switch_count == last_count_ff + 32'd1) ||
         (!rsp_switched && rsp_switch_count == last_count_ff))
      else $error("switch count does not follow switched flag");

   a_link_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && have_last_ff && !rsp_switched |-> rsp_active_link == last_link_ff)
      else $error("active link changed without switched");

endmodule

bind link_failover_selector_unit lfs_checker u_lfs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_active_link  (rsp_if.active_link),
   .rsp_switched     (rsp_if.switched),
   .rsp_switch_count (rsp_if.switch_count)
);
